>>> sv/axr_pkg.sv
// ----------------------------------------------------------------------------
// axr_pkg
// Shared types, codes and helper functions for the add-xor-rotate cipher.
// ----------------------------------------------------------------------------
package axr_pkg;

  localparam int WORD_W  = 32;
  localparam int OP_W    = 2;
  localparam int INDEX_W = 3;
  localparam int COUNT_W = 3;
  localparam int MIX_N   = 8;
  localparam int NONCE_N = 4;

  typedef logic [WORD_W-1:0]  word_t;
  typedef logic [OP_W-1:0]    op_t;
  typedef logic [INDEX_W-1:0] index_t;
  typedef logic [COUNT_W-1:0] count_t;

  localparam op_t OP_LOAD_KEY   = 2'd0;
  localparam op_t OP_LOAD_NONCE = 2'd1;
  localparam op_t OP_SETUP      = 2'd2;
  localparam op_t OP_CRYPT      = 2'd3;

  localparam count_t COUNT_MIN = 3'd1;
  localparam count_t COUNT_MAX = 3'd4;

  function automatic word_t rotl2(input word_t x);
    return {x[WORD_W-3:0], x[WORD_W-1:WORD_W-2]};
  endfunction

  // Clamp a byte count into 1..4.
  function automatic count_t sat_count(input count_t c);
    count_t r;
    if (c == 3'd0) begin
      r = COUNT_MIN;
    end else if (c > COUNT_MAX) begin
      r = COUNT_MAX;
    end else begin
      r = c;
    end
    return r;
  endfunction

  // Keep the low bytes that the count marks valid.
  function automatic word_t byte_mask(input count_t c);
    word_t m;
    case (c)
      3'd1:    m = 32'h0000_00FF;
      3'd2:    m = 32'h0000_FFFF;
      3'd3:    m = 32'h00FF_FFFF;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

>>> sv/axr_if.sv
// ----------------------------------------------------------------------------
// axr_in_if / axr_out_if
// Valid/ready channels for request transactions and result transactions.
// ----------------------------------------------------------------------------
interface axr_in_if;
  import axr_pkg::*;

  logic   valid;
  logic   ready;
  op_t    op;
  index_t word_index;
  word_t  word_value;
  word_t  data_word;
  count_t byte_count;

  modport source (output valid, op, word_index, word_value, data_word, byte_count,
                  input ready);
  modport sink   (input valid, op, word_index, word_value, data_word, byte_count,
                  output ready);
endinterface

interface axr_out_if;
  import axr_pkg::*;

  logic   valid;
  logic   ready;
  word_t  out_word;
  count_t out_count;

  modport source (output valid, out_word, out_count, input ready);
  modport sink   (input valid, out_word, out_count, output ready);
endinterface

>>> sv/add_xor_rotate_stream_cipher_top.sv
// ----------------------------------------------------------------------------
// add_xor_rotate_stream_cipher_top
// 32-bit add-xor-rotate stream cipher with key/nonce stores and a shared
// round unit stepped by a small sequencer.
//
//   channel   direction  payload                                       
//   in_ch     sink       op, word_index, word_value, data_word, byte_count
//   out_ch    source     out_word, out_count (crypt requests only)
//
// Key and nonce loads complete on acceptance. Setup accepts, then takes eight
// steps to accumulate the register sum and eight for the round. Crypt accepts,
// then runs eight round steps and four keystream steps. The round unit handles
// one mixing register per cycle; only the last keystream step can stall.
// Reset is synchronous and clears all stores and mixing state. A stalled
// result holds in the output register; a crypt that finishes behind it waits.
// ----------------------------------------------------------------------------
module add_xor_rotate_stream_cipher_top
  import axr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  axr_in_if.sink    in_ch,
  axr_out_if.source out_ch
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SUM   = 2'd1;
  localparam logic [1:0] ST_ROUND = 2'd2;
  localparam logic [1:0] ST_KS    = 2'd3;

  logic [1:0] state;
  logic [2:0] step;
  logic       crypt;
  word_t      data;
  count_t     count;
  word_t      ks;
  word_t      ks_next;
  word_t      mix [MIX_N];
  word_t      sum;
  word_t      ctr;
  word_t      key_mem [MIX_N];
  word_t      nonce_mem [NONCE_N];
  word_t      t;
  logic       in_fire;
  logic       out_free;
  logic       out_valid;
  word_t      out_word;
  count_t     out_count;

  assign in_ch.ready     = (state == ST_IDLE);
  assign in_fire         = in_ch.valid && in_ch.ready;
  assign out_free        = !out_valid || out_ch.ready;
  assign out_ch.valid    = out_valid;
  assign out_ch.out_word = out_word;
  assign out_ch.out_count = out_count;

  // Round update for the register at the head of the rotating line.
  assign t = rotl2((mix[0] + mix[1] + sum) ^ mix[0]);

  always_comb begin
    case (step[1:0])
      2'd0:    ks_next = mix[0] + mix[6];
      2'd1:    ks_next = (ks ^ mix[1]) + mix[5];
      2'd2:    ks_next = (ks ^ mix[2]) + mix[4];
      default: ks_next = (ks ^ mix[3]) + mix[7];
    endcase
  end

  // Key and nonce stores.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MIX_N; i++) key_mem[i] <= '0;
      for (int i = 0; i < NONCE_N; i++) nonce_mem[i] <= '0;
    end else if (in_fire) begin
      if (in_ch.op == OP_LOAD_KEY) begin
        key_mem[in_ch.word_index] <= in_ch.word_value;
      end
      if (in_ch.op == OP_LOAD_NONCE && !in_ch.word_index[2]) begin
        nonce_mem[in_ch.word_index[1:0]] <= in_ch.word_value;
      end
    end
  end

  // Sequencer and mixing state. The mixing registers rotate by one each sum
  // and round step, so the unit always works on positions 0 and 1.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
      crypt <= 1'b0;
      ks    <= '0;
      sum   <= '0;
      ctr   <= '0;
      for (int i = 0; i < MIX_N; i++) mix[i] <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          step <= '0;
          if (in_fire && in_ch.op == OP_SETUP) begin
            // Fold the nonce words into the upper half.
            for (int i = 0; i < NONCE_N; i++) begin
              mix[i]           <= key_mem[i];
              mix[i + NONCE_N] <= key_mem[i + NONCE_N] ^ nonce_mem[i];
            end
            sum   <= '0;
            ctr   <= '0;
            crypt <= 1'b0;
            state <= ST_SUM;
          end else if (in_fire && in_ch.op == OP_CRYPT) begin
            crypt <= 1'b1;
            state <= ST_ROUND;
          end
        end
        ST_SUM: begin
          sum <= sum + mix[0];
          for (int i = 0; i < MIX_N-1; i++) mix[i] <= mix[i+1];
          mix[MIX_N-1] <= mix[0];
          step <= step + 3'd1;
          if (step == 3'd7) begin
            state <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          sum <= sum + t + ctr;
          ctr <= ctr + 32'd1;
          for (int i = 0; i < MIX_N-1; i++) mix[i] <= mix[i+1];
          mix[MIX_N-1] <= t;
          step <= step + 3'd1;
          if (step == 3'd7) begin
            state <= crypt ? ST_KS : ST_IDLE;
          end
        end
        default: begin
          // Hold the last keystream step until the output register frees up.
          if (step[1:0] != 2'd3) begin
            ks   <= ks_next;
            step <= step + 3'd1;
          end else if (out_free) begin
            ks    <= ks_next;
            step  <= '0;
            state <= ST_IDLE;
          end
        end
      endcase
    end
  end

  // Latch request payload for crypt.
  always_ff @(posedge clk) begin
    if (in_fire && in_ch.op == OP_CRYPT) begin
      data  <= in_ch.data_word;
      count <= sat_count(in_ch.byte_count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_KS && step[1:0] == 2'd3 && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_KS && step[1:0] == 2'd3 && out_free) begin
      out_word  <= (data ^ ks_next) & byte_mask(count);
      out_count <= count;
    end
  end

endmodule

>>> sv/axr_checker.sv
// ----------------------------------------------------------------------------
// axr_checker
// Port-level checks for the cipher top level, attached by bind.
// ----------------------------------------------------------------------------
module axr_checker
  import axr_pkg::*;
(
  input logic   clk,
  input logic   rst,
  input logic   in_valid,
  input logic   in_ready,
  input op_t    in_op,
  input logic   out_valid,
  input logic   out_ready,
  input word_t  out_word,
  input count_t out_count
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_word) && $stable(out_count))
    else $error("result changed while stalled");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_count == 3'd1 || out_count == 3'd2 ||
                   out_count == 3'd3 || out_count == 3'd4))
    else $error("result byte count out of range");

  a_high_bytes_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_word & ~byte_mask(out_count)) == '0)
    else $error("bytes beyond count not zero");

  // Setup and crypt occupy the round unit, so ready drops after acceptance.
  a_busy_after_run: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_op == OP_SETUP || in_op == OP_CRYPT) |=> !in_ready)
    else $error("ready right after a setup or crypt transaction");

endmodule

bind add_xor_rotate_stream_cipher_top axr_checker u_axr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_op     (in_ch.op),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_word  (out_ch.out_word),
  .out_count (out_ch.out_count)
);

>>> bench/add_xor_rotate_stream_cipher_checker.sv
// ----------------------------------------------------------------------------
// add_xor_rotate_stream_cipher_checker
// Watches the request and result channels of the cipher. Keeps its own copy
// of the key/nonce stores and mixing state, predicts the output word and
// byte count of each crypt transaction, and compares every result
// transaction against the oldest prediction in order.
// ----------------------------------------------------------------------------
module add_xor_rotate_stream_cipher_checker
  import axr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  axr_in_if    in_ch,
  axr_out_if   out_ch,
  output int   fail_count,
  output int   pending_results
);

  typedef struct packed {
    word_t  word;
    count_t count;
  } cipher_result_t;

  word_t key_words   [MIX_N];
  word_t nonce_words [NONCE_N];
  word_t mix         [MIX_N];
  word_t mix_sum;
  word_t step_count;

  cipher_result_t expected_ciphers[$];
  int mismatches = 0;

  // Eight chained updates, each one feeding the running sum of the next.
  function automatic void mix_round();
    word_t prev;
    word_t t;
    for (int i = 0; i < MIX_N; i++) begin
      prev = mix[i];
      t = (prev + mix[(i + 1) % MIX_N] + mix_sum) ^ prev;
      t = (t << 2) | (t >> (WORD_W - 2));
      mix[i] = t;
      mix_sum = mix_sum + t + step_count;
      step_count = step_count + 1;
    end
  endfunction

  function automatic word_t keystream_word();
    word_t k;
    k = mix[0] + mix[6];
    k = k ^ mix[1];
    k = k + mix[5];
    k = k ^ mix[2];
    k = k + mix[4];
    k = k ^ mix[3];
    k = k + mix[7];
    return k;
  endfunction

  always @(posedge clk) begin
    cipher_result_t exp_r;
    count_t cnt;
    word_t mask;
    if (rst) begin
      for (int i = 0; i < MIX_N; i++) begin
        key_words[i] = '0;
        mix[i] = '0;
      end
      for (int i = 0; i < NONCE_N; i++) begin
        nonce_words[i] = '0;
      end
      mix_sum = '0;
      step_count = '0;
      expected_ciphers.delete();
    end else begin
      // Retire results first; a result can never stem from a request of the
      // same edge.
      if (out_ch.valid && out_ch.ready) begin
        if (expected_ciphers.size() == 0) begin
          $display("%0t: unexpected result out_word=%h out_count=%0d", $time,
                   out_ch.out_word, out_ch.out_count);
          mismatches++;
        end else begin
          exp_r = expected_ciphers.pop_front();
          if (out_ch.out_word !== exp_r.word) begin
            $display("%0t: out_word expected %h actual %h", $time, exp_r.word,
                     out_ch.out_word);
            mismatches++;
          end
          if (out_ch.out_count !== exp_r.count) begin
            $display("%0t: out_count expected %0d actual %0d", $time, exp_r.count,
                     out_ch.out_count);
            mismatches++;
          end
        end
      end

      if (in_ch.valid && in_ch.ready) begin
        case (in_ch.op)
          OP_LOAD_KEY: begin
            key_words[in_ch.word_index] = in_ch.word_value;
          end
          OP_LOAD_NONCE: begin
            // Drop loads past the last nonce word.
            if (in_ch.word_index < NONCE_N) begin
              nonce_words[in_ch.word_index[1:0]] = in_ch.word_value;
            end
          end
          OP_SETUP: begin
            for (int i = 0; i < MIX_N; i++) begin
              mix[i] = key_words[i];
            end
            for (int i = 0; i < NONCE_N; i++) begin
              mix[NONCE_N + i] = mix[NONCE_N + i] ^ nonce_words[i];
            end
            mix_sum = '0;
            step_count = '0;
            for (int i = 0; i < MIX_N; i++) begin
              mix_sum = mix_sum + mix[i];
            end
            mix_round();
          end
          OP_CRYPT: begin
            mix_round();
            cnt = in_ch.byte_count;
            if (cnt == 3'd0) begin
              cnt = COUNT_MIN;
            end else if (cnt > COUNT_MAX) begin
              cnt = COUNT_MAX;
            end
            mask = (cnt == COUNT_MAX) ? '1 : ((word_t'(1) << (8 * cnt)) - 1);
            exp_r.word = (in_ch.data_word ^ keystream_word()) & mask;
            exp_r.count = cnt;
            expected_ciphers.push_back(exp_r);
          end
        endcase
      end
    end
    pending_results <= expected_ciphers.size();
    fail_count <= mismatches;
  end

endmodule

>>> bench/add_xor_rotate_stream_cipher_top_test.sv
// ----------------------------------------------------------------------------
// add_xor_rotate_stream_cipher_top_test
// Drives key, nonce, setup and crypt transactions into the cipher: a short
// directed pass over the edge cases, then random key/nonce/setup/crypt
// sessions mixed with noise, with random idle bursts on both channels.
// A separate checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module add_xor_rotate_stream_cipher_top_test;
  import axr_pkg::*;

  localparam int ITEM_TARGET   = 1550;
  localparam int QUIET_FROM    = 1300;
  localparam int STALL_LIMIT   = 1000;
  localparam int SETTLE_CYCLES = 20;

  logic clk = 1'b0;
  logic rst = 1'b1;

  axr_in_if  in_ch ();
  axr_out_if out_ch ();

  int fail_count;
  int pending_results;
  int sent = 0;
  int quiet_cycles = 0;
  bit sender_idle = 1'b0;
  bit sink_idle = 1'b0;

  add_xor_rotate_stream_cipher_top i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  add_xor_rotate_stream_cipher_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  always #5 clk = ~clk;

  // End the run when no transaction moves on either channel for too long.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Result side back-pressure.
  initial begin
    int stall;
    stall = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        stall--;
      end else if (sink_idle && $urandom_range(0, 4) == 0) begin
        stall = $urandom_range(1, 4) - 1;
        out_ch.ready = 1'b0;
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_request(input op_t op, input index_t idx, input word_t value,
                              input word_t data, input count_t cnt);
    int gap;
    if (sender_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid      = 1'b1;
    in_ch.op         = op;
    in_ch.word_index = idx;
    in_ch.word_value = value;
    in_ch.data_word  = data;
    in_ch.byte_count = cnt;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic wait_results_drained();
    in_ch.valid = 1'b0;
    while (pending_results != 0) @(negedge clk);
  endtask

  function automatic word_t pick_word();
    word_t w;
    case ($urandom_range(0, 9))
      0:       w = '0;
      1:       w = '1;
      default: w = $urandom;
    endcase
    return w;
  endfunction

  function automatic count_t pick_count(input bit last_word);
    count_t c;
    if ($urandom_range(0, 9) == 0) begin
      c = count_t'($urandom_range(0, 7));
    end else if (last_word) begin
      c = count_t'($urandom_range(1, 4));
    end else begin
      c = COUNT_MAX;
    end
    return c;
  endfunction

  task automatic send_crypt(input count_t cnt);
    send_request(OP_CRYPT, index_t'($urandom), $urandom, pick_word(), cnt);
  endtask

  task automatic run_session();
    int n;
    if ($urandom_range(0, 3) != 0) begin
      for (int i = 0; i < MIX_N; i++) begin
        send_request(OP_LOAD_KEY, index_t'(i), pick_word(), $urandom,
                     count_t'($urandom));
      end
    end else begin
      n = $urandom_range(1, 4);
      repeat (n) send_request(OP_LOAD_KEY, index_t'($urandom), pick_word(), $urandom,
                              count_t'($urandom));
    end
    for (int i = 0; i < NONCE_N; i++) begin
      send_request(OP_LOAD_NONCE, index_t'(i), pick_word(), $urandom, count_t'($urandom));
    end
    if ($urandom_range(0, 4) == 0) begin
      send_request(OP_LOAD_NONCE, index_t'($urandom_range(4, 7)), pick_word(), $urandom,
                   count_t'($urandom));
    end
    // Occasionally keep running the old stream without a fresh setup.
    if ($urandom_range(0, 9) != 0) begin
      send_request(OP_SETUP, index_t'($urandom), $urandom, $urandom, count_t'($urandom));
    end
    n = $urandom_range(1, 16);
    for (int i = 0; i < n; i++) begin
      send_crypt(pick_count(i == n - 1));
    end
  endtask

  initial begin
    int n;
    in_ch.valid      = 1'b0;
    in_ch.op         = OP_LOAD_KEY;
    in_ch.word_index = '0;
    in_ch.word_value = '0;
    in_ch.data_word  = '0;
    in_ch.byte_count = COUNT_MAX;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // Crypt on the all-zero state left by reset.
    send_crypt(COUNT_MAX);
    for (int i = 0; i < MIX_N; i++) begin
      case (i)
        1:       send_request(OP_LOAD_KEY, index_t'(i), 32'h0000_0000, '0, COUNT_MAX);
        3:       send_request(OP_LOAD_KEY, index_t'(i), 32'h8000_0000, '0, COUNT_MAX);
        5:       send_request(OP_LOAD_KEY, index_t'(i), 32'h0000_0001, '0, COUNT_MAX);
        7:       send_request(OP_LOAD_KEY, index_t'(i), $urandom, '0, COUNT_MAX);
        default: send_request(OP_LOAD_KEY, index_t'(i), 32'hFFFF_FFFF, '0, COUNT_MAX);
      endcase
    end
    send_request(OP_LOAD_NONCE, 3'd0, 32'hFFFF_FFFF, '0, COUNT_MAX);
    send_request(OP_LOAD_NONCE, 3'd1, 32'h0000_0000, '0, COUNT_MAX);
    send_request(OP_LOAD_NONCE, 3'd2, $urandom, '0, COUNT_MAX);
    send_request(OP_LOAD_NONCE, 3'd3, 32'h8000_0001, '0, COUNT_MAX);
    // Out-of-range nonce indexes leave the store alone.
    send_request(OP_LOAD_NONCE, 3'd4, 32'hFFFF_FFFF, '0, COUNT_MAX);
    send_request(OP_LOAD_NONCE, 3'd7, 32'hFFFF_FFFF, '0, COUNT_MAX);
    send_request(OP_SETUP, 3'd0, '0, '0, COUNT_MAX);
    // Every byte count, including zero and the ones above four.
    for (int c = 0; c < 8; c++) begin
      send_crypt(count_t'(c));
    end
    // A key load after setup only matters at the next setup.
    send_request(OP_LOAD_KEY, 3'd3, 32'hFFFF_FFFF, '0, COUNT_MAX);
    send_request(OP_CRYPT, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, COUNT_MAX);
    wait_results_drained();
    send_request(OP_SETUP, 3'd7, '1, '1, 3'd7);

    while (sent < ITEM_TARGET) begin
      if (sent > QUIET_FROM) begin
        sender_idle = 1'b0;
        sink_idle   = 1'b0;
      end else begin
        sender_idle = ($urandom_range(0, 3) != 0);
        sink_idle   = ($urandom_range(0, 3) != 0);
      end
      if ($urandom_range(0, 6) == 0) begin
        n = $urandom_range(1, 6);
        repeat (n) send_request(op_t'($urandom), index_t'($urandom), pick_word(),
                                $urandom, count_t'($urandom));
      end else begin
        run_session();
      end
      if ($urandom_range(0, 7) == 0) begin
        wait_results_drained();
      end
    end

    wait_results_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
